>>> rtl/oale_pkg.sv
// Shared constants for the ordered array list engine: list size, field widths,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned ADDR_W     = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned OCNT_W = 7;

  localparam int unsigned IN_BITS  = OP_W + POS_W + VAL_W;
  localparam int unsigned OUT_BITS = STS_W + OCNT_W + VAL_W;
  localparam int unsigned IN_TW    = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INS_SHIFT = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_SHIFT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_SWAP  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_SWAP  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

endpackage

`default_nettype wire

>>> rtl/ordered_array_list_engine_unit.sv
// Ordered array list engine: packed list in a synchronous RAM with a copy sequencer
// that moves elements one per cycle. Depends on oale_pkg.
// Each item passes through a copy phase and a final step before its result registers; the
// copy phase reads count - pos entries for insert shift, count - pos - 1 for delete shift,
// 1 for other accepted swaps and reads, and none for appends, tail delete shifts, unused
// codes and rejected items. One item is in work at a time; the next transfer is accepted
// once the result registers are loaded. Reset clears the count and control; RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine_unit
  import oale_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [2:0] operation, [8:3] position, [40:9] new_value
  input  wire  [IN_TW-1:0]    s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  // [1:0] status, [8:2] element_count, [40:9] read_value
  output logic [OUT_TW-1:0]   m_axis_tdata_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COPY  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [STS_W-1:0]  sts_q, sts_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              up_q, up_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_dst_q, pend_dst_d;
  logic [VAL_W-1:0]  rdv_q, rdv_d;

  logic              ovalid_q, ovalid_d;
  logic [STS_W-1:0]  osts_q, osts_d;
  logic [OCNT_W-1:0] ocnt_q, ocnt_d;
  logic [VAL_W-1:0]  oval_q, oval_d;

  logic [VAL_W-1:0]  list_mem [LIST_DEPTH];
  logic [VAL_W-1:0]  mem_rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata;

  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [CNT_W-1:0]  pos_ext;
  logic [STS_W-1:0]  in_sts;
  logic              in_xfer;
  logic              fin_done;
  logic              op_ok;

  assign in_op   = s_axis_tdata_i[OP_W-1:0];
  assign in_pos  = s_axis_tdata_i[OP_W+POS_W-1:OP_W];
  assign in_val  = s_axis_tdata_i[IN_BITS-1:OP_W+POS_W];
  assign pos_ext = CNT_W'(in_pos);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_done        = (state_q == ST_FINAL) && (!ovalid_q || m_axis_tready_i);
  assign op_ok           = (sts_q == STS_OK);

  // Bounds checks on the incoming item; full is checked before range on inserts.
  always_comb begin
    in_sts = STS_OK;
    case (in_op)
      OP_INS_SHIFT, OP_INS_SWAP: begin
        if (cnt_q == CNT_W'(LIST_DEPTH)) begin
          in_sts = STS_FULL;
        end else if (pos_ext > cnt_q) begin
          in_sts = STS_RANGE;
        end
      end
      OP_DEL_SHIFT, OP_DEL_SWAP, OP_READ: begin
        if (pos_ext >= cnt_q) begin
          in_sts = STS_RANGE;
        end
      end
      default: in_sts = STS_OK;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pos_d      = pos_q;
    val_d      = val_q;
    sts_d      = sts_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    dst_d      = dst_q;
    left_d     = left_q;
    up_d       = up_q;
    pend_d     = pend_q;
    pend_dst_d = pend_dst_q;
    rdv_d      = rdv_q;
    ovalid_d   = ovalid_q && !m_axis_tready_i;
    osts_d     = osts_q;
    ocnt_d     = ocnt_q;
    oval_d     = oval_q;
    mem_we     = 1'b0;
    mem_waddr  = pend_dst_q;
    mem_wdata  = mem_rdata_q;
    mem_re     = 1'b0;
    mem_raddr  = src_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d    = in_op;
          pos_d   = ADDR_W'(in_pos);
          val_d   = in_val;
          sts_d   = in_sts;
          pend_d  = 1'b0;
          up_d    = 1'b0;
          src_d   = ADDR_W'(in_pos);
          dst_d   = ADDR_W'(in_pos);
          left_d  = '0;
          state_d = ST_COPY;
          if (in_sts == STS_OK) begin
            case (in_op)
              OP_INS_SHIFT: begin
                src_d  = cnt_q[ADDR_W-1:0] - ADDR_W'(1);
                dst_d  = cnt_q[ADDR_W-1:0];
                left_d = cnt_q - pos_ext;
              end
              OP_DEL_SHIFT: begin
                up_d   = 1'b1;
                src_d  = ADDR_W'(in_pos) + ADDR_W'(1);
                left_d = cnt_q - pos_ext - CNT_W'(1);
              end
              OP_INS_SWAP: begin
                dst_d  = cnt_q[ADDR_W-1:0];
                left_d = (pos_ext != cnt_q) ? CNT_W'(1) : '0;
              end
              OP_DEL_SWAP: begin
                src_d  = cnt_q[ADDR_W-1:0] - ADDR_W'(1);
                left_d = CNT_W'(1);
              end
              OP_READ: begin
                left_d = CNT_W'(1);
              end
              default: left_d = '0;
            endcase
          end
        end
      end

      ST_COPY: begin
        // Write back the element read last cycle, or hold it for a read result.
        if (pend_q) begin
          if (op_q == OP_READ) begin
            rdv_d = mem_rdata_q;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (left_q != '0) begin
          mem_re     = 1'b1;
          pend_d     = 1'b1;
          pend_dst_d = dst_q;
          left_d     = left_q - CNT_W'(1);
          src_d      = up_q ? src_q + ADDR_W'(1) : src_q - ADDR_W'(1);
          dst_d      = up_q ? dst_q + ADDR_W'(1) : dst_q - ADDR_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        if (fin_done) begin
          if (op_ok) begin
            case (op_q)
              OP_INS_SHIFT, OP_INS_SWAP: begin
                mem_we    = 1'b1;
                mem_waddr = pos_q;
                mem_wdata = val_q;
                cnt_d     = cnt_q + CNT_W'(1);
              end
              OP_DEL_SHIFT, OP_DEL_SWAP: begin
                cnt_d = cnt_q - CNT_W'(1);
              end
              default: cnt_d = cnt_q;
            endcase
          end
          ovalid_d = 1'b1;
          osts_d   = sts_q;
          ocnt_d   = OCNT_W'(cnt_d);
          oval_d   = (op_ok && op_q == OP_READ) ? rdv_q : '0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      left_q   <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    sts_q      <= sts_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    up_q       <= up_d;
    pend_dst_q <= pend_dst_d;
    rdv_q      <= rdv_d;
    osts_q     <= osts_d;
    ocnt_q     <= ocnt_d;
    oval_q     <= oval_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= list_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {(OUT_TW - OUT_BITS)'(0), oval_q, ocnt_q, osts_q};

  cnt_bound_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LIST_DEPTH))
    else $error("list count above depth");

  rw_clash_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("RAM read and write hit the same entry");

  left_idle_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COPY) |-> (left_q == '0 && !pend_q))
    else $error("copy work pending outside copy phase");

  out_src_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_FINAL))
    else $error("result raised outside final step");

  cnt_step_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FINAL) |=> $stable(cnt_q))
    else $error("count changed outside final step");

endmodule

`default_nettype wire
